@@ src/sfdd_pkg.sv @@
// Shared types and constants for the sensor frame delta decoder.
// No dependencies; imported by every module of the block.

package sfdd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 24;
    localparam int STAMP_W      = 32;
    localparam int AXIS_OUT_W   = 3;
    localparam int SENSOR_OUT_W = 6;
    localparam int SCALED_W     = 40;
    localparam int CFG_INDEX_W  = 8;

    // Axes below this number use the accelerometer gain
    localparam int ACCEL_AXES = 3;

    // Gain reset value: 1.0 in Q8.16
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // Element kinds
    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_DELTA = 2'd1,
        KIND_OTHER = 2'd2
    } frame_kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEL_GAIN = 8'd0,
        CFG_GYRO_GAIN  = 8'd1
    } cfg_reg_t;

    // Gain register pair
    typedef struct packed {
        logic [GAIN_W-1:0] accel;
        logic [GAIN_W-1:0] gyro;
    } gains_t;

    // Add a signed 8-bit delta (low byte of the sample), wrapping mod 2^16
    function automatic logic [SAMPLE_W-1:0] apply_delta(
        input logic [SAMPLE_W-1:0] value,
        input logic [SAMPLE_W-1:0] sample
    );
        logic [SAMPLE_W-1:0] delta;
        delta = {{(SAMPLE_W-8){sample[7]}}, sample[7:0]};
        return value + delta;
    endfunction

endpackage

@@ src/sfdd_position.sv @@
// Element position tracker: flat position plus axis and sensor counters.
// Depends on sfdd_pkg.

module sfdd_position import sfdd_pkg::*; #(
    parameter int AXES     = 6,
    parameter int SENSORS  = 64,
    parameter int CELLS    = AXES * SENSORS,
    parameter int POS_W    = (CELLS > 1) ? $clog2(CELLS) : 1,
    parameter int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1,
    parameter int SENSOR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                frame_end,
    output logic [POS_W-1:0]    pos,
    output logic [AXIS_W-1:0]   axis,
    output logic [SENSOR_W-1:0] sensor
);

    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [AXIS_W-1:0]   axis_reg,   axis_next;
    logic [SENSOR_W-1:0] sensor_reg, sensor_next;

    // Step to the next place, back to zero at frame end or the last place
    always_comb begin
        pos_next    = pos_reg;
        axis_next   = axis_reg;
        sensor_next = sensor_reg;
        if (advance) begin
            if (frame_end || pos_reg == POS_W'(CELLS - 1)) begin
                pos_next    = '0;
                axis_next   = '0;
                sensor_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (sensor_reg == SENSOR_W'(SENSORS - 1)) begin
                    sensor_next = '0;
                    axis_next   = axis_reg + AXIS_W'(1);
                end else begin
                    sensor_next = sensor_reg + SENSOR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            axis_reg   <= '0;
            sensor_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            axis_reg   <= axis_next;
            sensor_reg <= sensor_next;
        end
    end

    assign pos    = pos_reg;
    assign axis   = axis_reg;
    assign sensor = sensor_reg;

endmodule

@@ src/sfdd_store.sv @@
// Value store: one-write one-read memory with registered read, a fill count
// standing in for the all-zero reset, and a bypass for a read of the place being written.
// Depends on sfdd_pkg.

module sfdd_store import sfdd_pkg::*; #(
    parameter int CELLS  = 384,
    parameter int POS_W  = (CELLS > 1) ? $clog2(CELLS) : 1,
    parameter int FILL_W = $clog2(CELLS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [POS_W-1:0]    rd_addr,
    input  logic                wr_en,
    input  logic [POS_W-1:0]    wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [CELLS];
    logic [SAMPLE_W-1:0] mem_q;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                rd_written;
    logic                rd_bypass;

    // Places are visited as a prefix and every visit writes, so everything
    // below the fill count has been written; at or above it reads as zero.
    always_comb begin
        fill_next = fill_reg;
        if (wr_en && FILL_W'(wr_addr) >= fill_reg) begin
            fill_next = FILL_W'(wr_addr) + FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q <= mem[rd_addr];
        end
    end

    assign rd_written = FILL_W'(rd_addr) < fill_reg;
    assign rd_bypass  = wr_en && (wr_addr == rd_addr);

    // Read qualifiers, registered alongside the memory output
    logic rd_written_reg, rd_bypass_reg;
    logic [SAMPLE_W-1:0] bypass_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_written_reg  <= rd_written;
            rd_bypass_reg   <= rd_bypass;
            bypass_data_reg <= wr_data;
        end
    end

    always_comb begin
        if (rd_bypass_reg) begin
            rd_data = bypass_data_reg;
        end else if (rd_written_reg) begin
            rd_data = mem_q;
        end else begin
            rd_data = '0;
        end
    end

endmodule

@@ src/sfdd_scale.sv @@
// Element update and gain multiply: new stored value, drop decision and
// the Q24.16 product. Depends on sfdd_pkg.

module sfdd_scale import sfdd_pkg::*; #(
    parameter int AXIS_W = 3
) (
    input  logic [1:0]          kind,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] stored,
    input  logic                base_seen,
    input  logic [AXIS_W-1:0]   axis,
    input  gains_t              gains,
    output logic [SAMPLE_W-1:0] new_value,
    output logic                drop,
    output logic [SCALED_W-1:0] scaled
);

    logic [AXIS_W+2:0]     axis_ext;
    logic [GAIN_W-1:0]     gain;
    logic signed [SCALED_W:0] product;

    // Update of the stored value by element kind
    always_comb begin
        drop = 1'b0;
        case (kind)
            KIND_RAW: begin
                new_value = sample;
            end
            KIND_DELTA: begin
                if (base_seen) begin
                    new_value = apply_delta(stored, sample);
                end else begin
                    new_value = stored;
                    drop      = 1'b1;
                end
            end
            default: begin
                new_value = stored;
            end
        endcase
    end

    // Gain by axis group, signed x unsigned product
    assign axis_ext = {3'b000, axis};
    assign gain     = (axis_ext < (AXIS_W + 3)'(ACCEL_AXES)) ? gains.accel : gains.gyro;
    assign product  = $signed(new_value) * $signed({1'b0, gain});
    assign scaled   = product[SCALED_W-1:0];

endmodule

@@ src/sensor_frame_delta_decoder_unit.sv @@
// Sensor frame delta decoder, top level.
// An accepted request is registered in stage 1, then in the stage 2 result register.
// Throughput: one item per cycle while the result side is not stalled; the store read is issued at acceptance and
// the delta add and 16x24 gain multiply share the cycle between stages.
// Reset (aresetn, synchronous): clears control, position, gains and the
// store fill count; the store itself needs no clearing pass.

module sensor_frame_delta_decoder_unit import sfdd_pkg::*; #(
    parameter int AXES    = 6,
    parameter int SENSORS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]       cfg_data,
    // input elements
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_frame_kind,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic [STAMP_W-1:0]      s_frame_stamp,
    input  logic                    s_frame_end,
    // results
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [AXIS_OUT_W-1:0]   m_axis_index,
    output logic [SENSOR_OUT_W-1:0] m_sensor_index,
    output logic signed [SCALED_W-1:0] m_scaled_value,
    output logic [STAMP_W-1:0]      m_out_stamp,
    output logic                    m_last_of_frame
);

    localparam int CELLS    = AXES * SENSORS;
    localparam int POS_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SENSOR_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    logic                s_accept;
    logic [POS_W-1:0]    cur_pos;
    logic [AXIS_W-1:0]   cur_axis;
    logic [SENSOR_W-1:0] cur_sensor;

    // Configuration registers
    gains_t gains_reg, gains_next;

    always_comb begin
        gains_next = gains_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ACCEL_GAIN: gains_next.accel = cfg_data;
                CFG_GYRO_GAIN:  gains_next.gyro  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '{accel: GAIN_RESET, gyro: GAIN_RESET};
        end else begin
            gains_reg <= gains_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Position tracking, stepped on every accepted request
    sfdd_position #(
        .AXES    (AXES),
        .SENSORS (SENSORS)
    ) u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_accept),
        .frame_end (s_frame_end),
        .pos       (cur_pos),
        .axis      (cur_axis),
        .sensor    (cur_sensor)
    );

    // Stage 1: input register, store read in flight
    logic                s1_valid_reg;
    logic [1:0]          s1_kind_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [STAMP_W-1:0]  s1_stamp_reg;
    logic                s1_last_reg;
    logic [POS_W-1:0]    s1_pos_reg;
    logic [AXIS_W-1:0]   s1_axis_reg;
    logic [SENSOR_W-1:0] s1_sensor_reg;
    logic                base_seen_reg;

    logic [SAMPLE_W-1:0] s1_stored;
    logic [SAMPLE_W-1:0] s1_new_value;
    logic                s1_drop;
    logic [SCALED_W-1:0] s1_scaled;
    logic                s1_go;
    logic                out_valid_reg;

    assign s1_go    = s1_valid_reg && (s1_drop || !out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            base_seen_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && s1_kind_reg == KIND_RAW && s1_last_reg) begin
                base_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg   <= s_frame_kind;
            s1_sample_reg <= s_sample;
            s1_stamp_reg  <= s_frame_stamp;
            s1_last_reg   <= s_frame_end;
            s1_pos_reg    <= cur_pos;
            s1_axis_reg   <= cur_axis;
            s1_sensor_reg <= cur_sensor;
        end
    end

    // Value store; every element passing stage 1 writes back
    sfdd_store #(
        .CELLS (CELLS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (cur_pos),
        .wr_en   (s1_go),
        .wr_addr (s1_pos_reg),
        .wr_data (s1_new_value),
        .rd_data (s1_stored)
    );

    // Update and scaling
    sfdd_scale #(
        .AXIS_W (AXIS_W)
    ) u_scale (
        .kind      (s1_kind_reg),
        .sample    (s1_sample_reg),
        .stored    (s1_stored),
        .base_seen (base_seen_reg),
        .axis      (s1_axis_reg),
        .gains     (gains_reg),
        .new_value (s1_new_value),
        .drop      (s1_drop),
        .scaled    (s1_scaled)
    );

    // Stage 2: result register
    logic [AXIS_W+2:0]         axis_ext;
    logic [SENSOR_W+5:0]       sensor_ext;
    logic [AXIS_OUT_W-1:0]     out_axis_reg;
    logic [SENSOR_OUT_W-1:0]   out_sensor_reg;
    logic [SCALED_W-1:0]       out_scaled_reg;
    logic [STAMP_W-1:0]        out_stamp_reg;
    logic                      out_last_reg;
    logic                      out_load;

    assign axis_ext   = {3'b000, s1_axis_reg};
    assign sensor_ext = {6'b000000, s1_sensor_reg};
    assign out_load   = s1_go && !s1_drop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_axis_reg   <= axis_ext[AXIS_OUT_W-1:0];
            out_sensor_reg <= sensor_ext[SENSOR_OUT_W-1:0];
            out_scaled_reg <= s1_scaled;
            out_stamp_reg  <= s1_stamp_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_axis_index    = out_axis_reg;
    assign m_sensor_index  = out_sensor_reg;
    assign m_scaled_value  = out_scaled_reg;
    assign m_out_stamp     = out_stamp_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

@@ src/sfdd_checker.sv @@
// Port-level checks for the sensor frame delta decoder, and the bind that
// attaches them to the top level. Depends on sfdd_pkg.

module sfdd_checker import sfdd_pkg::*; #(
    parameter int AXES    = 6,
    parameter int SENSORS = 64
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [AXIS_OUT_W-1:0]   m_axis_index,
    input logic [SENSOR_OUT_W-1:0] m_sensor_index,
    input logic [SCALED_W-1:0]     m_scaled_value,
    input logic [STAMP_W-1:0]      m_out_stamp,
    input logic                    m_last_of_frame
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scaled_value)
            && $stable(m_axis_index) && $stable(m_sensor_index)
            && $stable(m_out_stamp) && $stable(m_last_of_frame))
        else $error("stalled result changed");

    // Axis index stays inside the frame
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (AXES > 8) || (int'(m_axis_index) < AXES))
        else $error("axis index out of range");

    // Sensor index stays inside the frame
    a_sensor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SENSORS > 64) || (int'(m_sensor_index) < SENSORS))
        else $error("sensor index out of range");

endmodule

bind sensor_frame_delta_decoder_unit sfdd_checker #(
    .AXES    (AXES),
    .SENSORS (SENSORS)
) u_sfdd_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for sensor_frame_delta_decoder_unit: drives frame elements and
// gain writes, predicts every decoded element and compares it field by field.
// Depends on sfdd_pkg and the RTL top level only.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdd_pkg::*;

    localparam int AXES          = 6;
    localparam int SENSORS       = 64;
    localparam int CELLS         = AXES * SENSORS;
    localparam int LATENCY       = 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int QUIET_AFTER   = 1650;
    // kind 3 has no name in the package but is legal on the 2-bit port
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One decoded element as the block reports it
    typedef struct packed {
        logic [AXIS_OUT_W-1:0]   axis;
        logic [SENSOR_OUT_W-1:0] sensor;
        logic signed [SCALED_W-1:0] scaled;
        logic [STAMP_W-1:0]      stamp;
        logic                    last;
    } decoded_t;

    // Frame rebuild predictor plus the queue of decoded elements still owed
    class frame_decode_scoreboard;
        logic [SAMPLE_W-1:0] cell_value [CELLS];
        bit                  key_seen;
        int unsigned         cursor;
        logic [GAIN_W-1:0]   accel_gain;
        logic [GAIN_W-1:0]   gyro_gain;
        decoded_t            owed_elements [$];
        int unsigned         n_errors;

        function new();
            foreach (cell_value[i]) cell_value[i] = '0;
            key_seen   = 1'b0;
            cursor     = 0;
            accel_gain = GAIN_RESET;
            gyro_gain  = GAIN_RESET;
            n_errors   = 0;
        endfunction

        function void set_gain(cfg_reg_t idx, logic [GAIN_W-1:0] value);
            if (idx == CFG_ACCEL_GAIN) begin
                accel_gain = value;
            end else if (idx == CFG_GYRO_GAIN) begin
                gyro_gain = value;
            end
        endfunction

        function int pending();
            return owed_elements.size();
        endfunction

        // Update the frame store for one accepted element and queue its result
        function void note_element(logic [1:0] kind, logic [SAMPLE_W-1:0] smp,
                                   logic [STAMP_W-1:0] stamp, logic fend);
            int unsigned        p;
            bit                 emit;
            logic [GAIN_W-1:0]  gain;
            logic signed [63:0] level;
            logic signed [63:0] gain64;
            logic signed [63:0] product;
            decoded_t           r;
            p    = (cursor >= CELLS) ? 0 : cursor;
            emit = 1'b1;
            if (kind == KIND_RAW) begin
                cell_value[p] = smp;
                if (fend) key_seen = 1'b1;
            end else if (kind == KIND_DELTA) begin
                // deltas are dropped until a raw element closing a frame has been seen
                if (!key_seen) begin
                    emit = 1'b0;
                end else begin
                    cell_value[p] = cell_value[p] + {{8{smp[7]}}, smp[7:0]};
                end
            end
            if (emit) begin
                gain     = ((p / SENSORS) < ACCEL_AXES) ? accel_gain : gyro_gain;
                level    = $signed(cell_value[p]);
                gain64   = {40'd0, gain};
                product  = level * gain64;
                r.axis   = AXIS_OUT_W'(p / SENSORS);
                r.sensor = SENSOR_OUT_W'(p % SENSORS);
                r.scaled = product[SCALED_W-1:0];
                r.stamp  = stamp;
                r.last   = fend;
                owed_elements.push_back(r);
            end
            cursor = (fend || p + 1 >= CELLS) ? 0 : p + 1;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            n_errors++;
        endtask

        // Compare one delivered element against the oldest one owed
        task check_result(logic [AXIS_OUT_W-1:0] axis, logic [SENSOR_OUT_W-1:0] sensor,
                          logic signed [SCALED_W-1:0] scaled, logic [STAMP_W-1:0] stamp,
                          logic last);
            decoded_t e;
            if (owed_elements.size() == 0) begin
                report($sformatf("unexpected result axis %0d sensor %0d", axis, sensor));
            end else begin
                e = owed_elements.pop_front();
                if (axis !== e.axis)
                    report($sformatf("axis_index %0d, want %0d", axis, e.axis));
                if (sensor !== e.sensor)
                    report($sformatf("sensor_index %0d, want %0d", sensor, e.sensor));
                if (scaled !== e.scaled)
                    report($sformatf("scaled_value %h, want %h (axis %0d sensor %0d)",
                                     scaled, e.scaled, e.axis, e.sensor));
                if (stamp !== e.stamp)
                    report($sformatf("out_stamp %h, want %h", stamp, e.stamp));
                if (last !== e.last)
                    report($sformatf("last_of_frame %b, want %b", last, e.last));
            end
        endtask
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [GAIN_W-1:0]          cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_frame_kind;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic [STAMP_W-1:0]         s_frame_stamp;
    logic                       s_frame_end;
    logic                       m_valid;
    logic                       m_ready;
    logic [AXIS_OUT_W-1:0]      m_axis_index;
    logic [SENSOR_OUT_W-1:0]    m_sensor_index;
    logic signed [SCALED_W-1:0] m_scaled_value;
    logic [STAMP_W-1:0]         m_out_stamp;
    logic                       m_last_of_frame;

    frame_decode_scoreboard decode_sb = new();
    bit          gaps_on;
    int unsigned items_sent;
    int unsigned cycle_count;

    sensor_frame_delta_decoder_unit #(
        .AXES    (AXES),
        .SENSORS (SENSORS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_kind    (s_frame_kind),
        .s_sample        (s_sample),
        .s_frame_stamp   (s_frame_stamp),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_index    (m_axis_index),
        .m_sensor_index  (m_sensor_index),
        .m_scaled_value  (m_scaled_value),
        .m_out_stamp     (m_out_stamp),
        .m_last_of_frame (m_last_of_frame)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result monitor and run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            decode_sb.check_result(m_axis_index, m_sensor_index, m_scaled_value,
                                   m_out_stamp, m_last_of_frame);
        end
    end

    // Result-side back-pressure in random bursts
    initial begin : result_pacing
        int unsigned stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one element request and hold it until accepted; entered at a falling edge
    task automatic send_element(logic [1:0] kind, logic [SAMPLE_W-1:0] smp,
                                logic [STAMP_W-1:0] stamp, logic fend);
        int unsigned idle;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            idle = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_frame_kind  <= kind;
        s_sample      <= smp;
        s_frame_stamp <= stamp;
        s_frame_end   <= fend;
        do @(posedge aclk); while (!s_ready);
        decode_sb.note_element(kind, smp, stamp, fend);
        items_sent++;
        if (items_sent >= QUIET_AFTER) begin
            gaps_on = 1'b0;
        end else if (items_sent % 128 == 0) begin
            gaps_on = ($urandom_range(0, 3) != 0);
        end
        @(negedge aclk);
    endtask

    // Stop sending, wait for every owed element, then cover dropped ones in flight
    task automatic settle();
        s_valid <= 1'b0;
        while (decode_sb.pending() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
    endtask

    // Write both gain registers back to back while the block is idle
    task automatic load_gains(logic [GAIN_W-1:0] accel, logic [GAIN_W-1:0] gyro);
        cfg_reg_t idx;
        for (int i = 0; i < 2; i++) begin
            idx = (i == 0) ? CFG_ACCEL_GAIN : CFG_GYRO_GAIN;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (i == 0) ? accel : gyro;
            do @(posedge aclk); while (!cfg_ready);
            decode_sb.set_gain(idx, (i == 0) ? accel : gyro);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random frames: mostly coherent raw or delta frames of mixed length, with noise
    task automatic play_frames(int unsigned budget);
        int unsigned        done;
        int unsigned        len;
        int unsigned        roll;
        logic [1:0]         frame_kind;
        logic [1:0]         kind;
        logic [STAMP_W-1:0] stamp;
        logic [SAMPLE_W-1:0] smp;
        bit                 skip_end;
        logic               fend;
        done = 0;
        while (done < budget) begin
            case ($urandom_range(0, 3))
                0:       len = CELLS;
                1:       len = $urandom_range(1, CELLS);
                default: len = $urandom_range(1, 24);
            endcase
            roll = $urandom_range(0, 19);
            if (roll < 7) begin
                frame_kind = KIND_RAW;
            end else if (roll < 18) begin
                frame_kind = KIND_DELTA;
            end else begin
                frame_kind = (roll == 18) ? KIND_OTHER : KIND_UNUSED;
            end
            case ($urandom_range(0, 9))
                0:       stamp = '0;
                1:       stamp = '1;
                default: stamp = $urandom;
            endcase
            // sometimes leave the end mark off so the position wraps or carries over
            skip_end = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < len && done < budget; k++) begin
                kind = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3)) : frame_kind;
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       smp = 16'h7FFF;
                        1:       smp = 16'h8000;
                        2:       smp = 16'h0000;
                        3:       smp = 16'hFFFF;
                        4:       smp = 16'h007F;
                        default: smp = 16'h0080;
                    endcase
                end else begin
                    smp = SAMPLE_W'($urandom);
                end
                fend = ((k == len - 1) && !skip_end) || ($urandom_range(0, 63) == 0);
                send_element(kind, smp, stamp, fend);
                done++;
            end
        end
    endtask

    initial begin : stimulus
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ACCEL_GAIN;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_frame_kind  = KIND_RAW;
        s_sample      = '0;
        s_frame_stamp = '0;
        s_frame_end   = 1'b0;
        gaps_on       = 1'b1;
        items_sent    = 0;
        cycle_count   = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Delta before any key frame is dropped; other kinds report the store
        send_element(KIND_DELTA,  16'h0005, 32'h0000_0000, 1'b0);
        send_element(KIND_OTHER,  16'h1234, 32'h0000_0000, 1'b0);
        send_element(KIND_UNUSED, 16'hFFFF, 32'h0000_0000, 1'b0);
        // Key frame with sample extremes; end mark arms delta decoding
        send_element(KIND_RAW, 16'h7FFF, 32'hFFFF_FFFF, 1'b0);
        send_element(KIND_RAW, 16'h8000, 32'hFFFF_FFFF, 1'b0);
        send_element(KIND_RAW, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_element(KIND_RAW, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        // Delta frame: delta extremes, wide delta, wrap both ways
        send_element(KIND_DELTA, 16'h007F, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_DELTA, 16'hFF80, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_DELTA, 16'hAB01, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_DELTA, 16'h0001, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_DELTA, 16'h00FF, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_DELTA, 16'h0001, 32'h5A5A_A5A5, 1'b0);
        send_element(KIND_OTHER, 16'h0000, 32'h5A5A_A5A5, 1'b1);
        // One-element key frame
        send_element(KIND_RAW, 16'h4000, 32'h0000_0001, 1'b1);
        settle();

        // Gain phases, extremes first
        load_gains(24'hFFFFFF, 24'hFFFFFF);
        play_frames(380);
        settle();
        load_gains(24'd0, 24'd0);
        play_frames(250);
        settle();
        load_gains(GAIN_W'($urandom_range(0, 24'hFFFFFF)), GAIN_W'($urandom_range(0, 24'hFFFFFF)));
        play_frames(400);
        settle();
        load_gains(GAIN_W'($urandom_range(0, 24'hFFFFFF)), 24'hFFFFFF);
        play_frames(400);
        settle();
        load_gains(GAIN_W'($urandom_range(0, 24'hFFFFFF)), GAIN_W'($urandom_range(0, 24'hFFFFFF)));
        play_frames(450);
        settle();
        repeat (LATENCY + 4) @(negedge aclk);

        if (decode_sb.n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sensor_frame_delta_decoder_unit.f @@
src/sfdd_pkg.sv
src/sfdd_position.sv
src/sfdd_store.sv
src/sfdd_scale.sv
src/sensor_frame_delta_decoder_unit.sv
src/sfdd_checker.sv
verif/tb.sv
